FILE: hw/rtl/tdpt_pkg.sv
`timescale 1ns / 1ps

package tdpt_pkg;

    // Default width of the candidate number.
    localparam int NUMBER_WIDTH_DEF = 16;

    // Smallest trial divisor.
    localparam int FIRST_DIVISOR = 2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // Capture a new candidate and restart the divisor sequence.
        logic div_start;   // Start a division of the candidate by the current divisor.
        logic div_step;    // Produce one remainder bit.
        logic next_div;    // Move to the next divisor and update its square.
        logic store_out;   // Load the output register.
        logic out_prime;   // Verdict written with store_out.
    } tdpt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic below_two;   // Candidate is zero or one.
        logic sq_above;    // Square of the divisor exceeds the candidate.
        logic div_last;    // The current step produces the final remainder bit.
        logic rem_zero;    // Remainder of the finished division is zero.
    } tdpt_status_t;

endpackage

FILE: hw/rtl/tdpt_dpath.sv
`timescale 1ns / 1ps

module tdpt_dpath
    import tdpt_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic [NUMBER_WIDTH-1:0] in_value,
    input  tdpt_cmd_t               cmd,
    output tdpt_status_t            status,
    output logic [NUMBER_WIDTH-1:0] out_value,
    output logic                    out_prime
);

    // Divisors never exceed two to the power of half the width, rounded up.
    localparam int DW = (NUMBER_WIDTH + 1) / 2 + 1;
    localparam int SW = 2 * DW;
    localparam int CW = $clog2(NUMBER_WIDTH);

    logic [NUMBER_WIDTH-1:0] n_reg,     n_next;
    logic [DW-1:0]           d_reg,     d_next;
    logic [SW-1:0]           sq_reg,    sq_next;
    logic [DW-1:0]           rem_reg,   rem_next;
    logic [NUMBER_WIDTH-1:0] shift_reg, shift_next;
    logic [CW-1:0]           cnt_reg,   cnt_next;
    logic [NUMBER_WIDTH-1:0] val_reg,   val_next;
    logic                    prime_reg, prime_next;

    logic [DW:0]             rem_shift;
    logic [DW:0]             rem_diff;

    assign rem_shift = {rem_reg, shift_reg[NUMBER_WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, d_reg};

    always_comb begin
        n_next     = n_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        prime_next = prime_reg;

        if (cmd.load) begin
            n_next  = in_value;
            d_next  = DW'(FIRST_DIVISOR);
            sq_next = SW'(FIRST_DIVISOR * FIRST_DIVISOR);
        end
        if (cmd.div_start) begin
            rem_next   = '0;
            shift_next = n_reg;
            cnt_next   = '0;
        end
        if (cmd.div_step) begin
            // Restoring division, one quotient bit per cycle of div_step; only the remainder is kept.
            if (rem_shift >= {1'b0, d_reg}) begin
                rem_next = rem_diff[DW-1:0];
            end else begin
                rem_next = rem_shift[DW-1:0];
            end
            shift_next = {shift_reg[NUMBER_WIDTH-2:0], 1'b0};
            cnt_next   = cnt_reg + CW'(1);
        end
        if (cmd.next_div) begin
            // (d + 1)^2 = d^2 + 2d + 1
            d_next  = d_reg + DW'(1);
            sq_next = sq_reg + SW'({d_reg, 1'b1});
        end
        if (cmd.store_out) begin
            val_next   = n_reg;
            prime_next = cmd.out_prime;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        cnt_reg   <= cnt_next;
        val_reg   <= val_next;
        prime_reg <= prime_next;
    end

    assign status.below_two = (n_reg < NUMBER_WIDTH'(FIRST_DIVISOR));
    assign status.sq_above  = (sq_reg > SW'(n_reg));
    assign status.div_last  = (cnt_reg == CW'(NUMBER_WIDTH - 1));
    assign status.rem_zero  = (rem_reg == '0);

    assign out_value = val_reg;
    assign out_prime = prime_reg;

endmodule

FILE: hw/rtl/tdpt_ctrl.sv
`timescale 1ns / 1ps

module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  tdpt_status_t status,
    output tdpt_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_DIV,
        S_EVAL,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   prime_reg, prime_next;
    logic   valid_reg, valid_next;
    logic   out_free;

    assign out_free = !valid_reg || out_ready;

    always_comb begin
        state_next    = state_reg;
        prime_next    = prime_reg;
        valid_next    = valid_reg && !out_ready;
        cmd           = '0;
        cmd.out_prime = prime_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_TEST;
                end
            end
            S_TEST: begin
                if (status.below_two) begin
                    prime_next = 1'b0;
                    state_next = S_OUT;
                end else if (status.sq_above) begin
                    prime_next = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (status.rem_zero) begin
                    prime_next = 1'b0;
                    state_next = S_OUT;
                end else begin
                    cmd.next_div = 1'b1;
                    state_next   = S_TEST;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.store_out = 1'b1;
                    valid_next    = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            prime_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            prime_reg <= prime_next;
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = valid_reg;

endmodule

FILE: hw/rtl/trial_division_prime_test.sv
`timescale 1ns / 1ps
// Candidates below four are decided without a division; otherwise one full division runs per
// trial divisor, at most about 2^(NUMBER_WIDTH/2) divisors, and a prime ends on a square test.
// Throughput: one beat at a time, taken in the idle cycle after the previous result is stored;
// the one-bit-per-cycle divider sets the rate, and a new beat is taken while a result waits.
// Reset: aresetn is synchronous and active low; it empties the output and idles the block.

module trial_division_prime_test
    import tdpt_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input channel: one candidate per beat.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [((NUMBER_WIDTH+7)/8)*8-1:0] s_tdata,   // [W-1:0] candidate, rest zero
    // Result channel: the candidate echoed with its verdict.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [((NUMBER_WIDTH+8)/8)*8-1:0] m_tdata    // [W-1:0] tested_value,
                                                         // [W] prime flag, rest zero
);

    localparam int OW = ((NUMBER_WIDTH + 8) / 8) * 8;

    tdpt_cmd_t               cmd;
    tdpt_status_t            status;
    logic [NUMBER_WIDTH-1:0] out_value;
    logic                    out_prime;

    // The controller sequences one candidate at a time: it tries divisors from two
    // upward while their square stays at or below the candidate, runs one full
    // division per divisor, and stops on the first zero remainder.
    tdpt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the candidate, the current divisor and its square, the
    // shift-and-subtract divider, and the output register that keeps a finished
    // result stable until the downstream side takes it.
    tdpt_dpath #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_dpath (
        .aclk      (aclk),
        .in_value  (s_tdata[NUMBER_WIDTH-1:0]),
        .cmd       (cmd),
        .status    (status),
        .out_value (out_value),
        .out_prime (out_prime)
    );

    // Verdict sits just above the echoed value; the remaining bits are zero.
    assign m_tdata = OW'({out_prime, out_value});

endmodule
